// File: rtl/bsfb_pkg.sv
// Package: shared types and constants for the bus to SPI ring bridge.
`default_nettype none
package bsfb_pkg;
  localparam int RingDepth = 256;
  localparam int RingAw = $clog2(RingDepth);
  localparam int MaxInFlight = 8;
  localparam int IdentLength = 8;
  localparam int IdentAw = $clog2(IdentLength);
  localparam int IflW = $clog2(MaxInFlight + 1);
  localparam int RateW = 27;

  localparam logic [2:0] MODE_READ = 3'd0;
  localparam logic [2:0] MODE_WRITE = 3'd1;
  localparam logic [2:0] MODE_RESET = 3'd2;
  localparam logic [2:0] MODE_RXBYTE = 3'd3;
  localparam logic [2:0] MODE_TXSLOT = 3'd4;
  localparam logic [2:0] MODE_CARD = 3'd5;

  localparam logic [3:0] REG_CARD = 4'd0;
  localparam logic [3:0] REG_UPPER = 4'd2;
  localparam logic [3:0] REG_RXHEAD = 4'd4;
  localparam logic [3:0] REG_RXTAIL = 4'd5;
  localparam logic [3:0] REG_TXHEAD = 4'd6;
  localparam logic [3:0] REG_TXTAIL = 4'd7;
  localparam logic [3:0] REG_DISCARD = 4'd8;
  localparam logic [3:0] REG_FEED = 4'd9;
  localparam logic [3:0] REG_RATE = 4'd10;
  localparam logic [3:0] REG_SELECT = 4'd11;
  localparam logic [3:0] REG_IRQ = 4'd12;
  localparam logic [3:0] REG_MASK = 4'd13;
  localparam logic [3:0] REG_DATA = 4'd14;
  localparam logic [3:0] REG_IDBYTE = 4'd15;

  localparam logic [7:0] FillerByte = 8'hff;
  localparam logic [RateW-1:0] RateAfterReset = RateW'(400 * 1000);

  typedef struct packed {
    logic [2:0] mode;
    logic [3:0] address;
    logic [7:0] write_data;
    logic [7:0] spi_rx_byte;
    logic       card_present;
  } req_t;

  typedef struct packed {
    logic [7:0]       read_data;
    logic             tx_valid;
    logic [7:0]       tx_byte;
    logic             rx_accepted;
    logic             irq_asserted;
    logic             select_active;
    logic [RateW-1:0] spi_rate_hz;
  } rsp_t;

  function automatic logic [7:0] ident_byte(input logic [3:0] pos);
    case (pos)
      4'd0: ident_byte = 8'hff;
      4'd1: ident_byte = 8'h73;
      4'd2: ident_byte = 8'h70;
      4'd3: ident_byte = 8'h64;
      4'd4: ident_byte = 8'h72;
      4'd5: ident_byte = 8'h01;
      default: ident_byte = 8'h00;
    endcase
  endfunction
endpackage
`default_nettype wire

// File: rtl/bus_to_spi_fifo_bridge.sv
// Top level: bus to SPI bridge with receive and transmit byte rings.
`default_nettype none
// One request per cycle is sustained while the result side accepts: a request
// is registered into a two-entry queue by the front end, then the engine does
// all state updates and one ring access in the same cycle, with the ring read
// data registered into the result stage. A request is held in a queue
// slot and then in the result stage register. The rings have no
// reset; their indices do. Request tuser: mode[2:0]. Request tdata (LSB first):
// address[3:0], write_data[7:0], spi_rx_byte[7:0], card_present, zero pad to
// 24 bits. Result tdata (LSB first): read_data[7:0], tx_valid, tx_byte[7:0],
// rx_accepted, irq_asserted, select_active, spi_rate_hz[26:0], pad to 48 bits.
module bus_to_spi_fifo_bridge (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [2:0]  s_axis_tuser,  // mode
  input  wire logic [23:0] s_axis_tdata,  // address, write_data, spi_rx_byte, card_present
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic      [47:0] m_axis_tdata   // read_data, tx_valid, tx_byte, rx_accepted,
                                          // irq_asserted, select_active, spi_rate_hz
);
  import bsfb_pkg::*;
  req_t in_req, q_req;
  rsp_t rsp;
  logic q_valid, q_ready;

  // Front end: unpack the request fields.
  always_comb begin
    in_req.mode         = s_axis_tuser;
    in_req.address      = s_axis_tdata[3:0];
    in_req.write_data   = s_axis_tdata[11:4];
    in_req.spi_rx_byte  = s_axis_tdata[19:12];
    in_req.card_present = s_axis_tdata[20];
  end

  bsfb_queue u_queue (
    .clk_i, .rst_ni, .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .in_req_i(in_req), .out_valid_o(q_valid), .out_ready_i(q_ready), .out_req_o(q_req)
  );

  bsfb_engine u_engine (
    .clk_i, .rst_ni, .req_valid_i(q_valid), .req_ready_o(q_ready), .req_i(q_req),
    .rsp_valid_o(m_axis_tvalid), .rsp_ready_i(m_axis_tready), .rsp_o(rsp)
  );

  assign m_axis_tdata = {1'b0, rsp.spi_rate_hz, rsp.select_active, rsp.irq_asserted,
                         rsp.rx_accepted, rsp.tx_byte, rsp.tx_valid, rsp.read_data};
endmodule
`default_nettype wire

// File: rtl/bsfb_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
`default_nettype none
module bsfb_ram #(
  parameter int Width = 8,
  parameter int Depth = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    if (re_i) rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

// File: rtl/bsfb_queue.sv
// Two-entry request queue between the front and back parts.
`default_nettype none
module bsfb_queue (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  input  wire bsfb_pkg::req_t in_req_i,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  output bsfb_pkg::req_t      out_req_o
);
  import bsfb_pkg::*;
  req_t slot_q [2];
  logic rd_q, wr_q;
  logic [1:0] cnt_q;
  logic push, pop;
  assign in_ready_o = cnt_q != 2'd2;
  assign out_valid_o = cnt_q != 2'd0;
  assign out_req_o = slot_q[rd_q];
  assign push = in_valid_i && in_ready_o;
  assign pop = out_valid_o && out_ready_i;
  always_ff @(posedge clk_i) begin
    if (push) slot_q[wr_q] <= in_req_i;
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_q <= 1'b0;
      wr_q <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wr_q <= ~wr_q;
      if (pop) rd_q <= ~rd_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule
`default_nettype wire

// File: rtl/bsfb_engine.sv
// Back part: carries out one request per cycle against state and rings while the result stage can advance.
`default_nettype none
module bsfb_engine (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           req_valid_i,
  output logic                req_ready_o,
  input  wire bsfb_pkg::req_t req_i,
  output logic                rsp_valid_o,
  input  wire logic           rsp_ready_i,
  output bsfb_pkg::rsp_t      rsp_o
);
  import bsfb_pkg::*;

  logic [RingAw-1:0] rx_head_q, rx_tail_q, tx_head_q, tx_tail_q;
  logic [31:0] discard_q, feed_q;
  logic [7:0] upper_q, mask_q;
  logic [IflW-1:0] ifl_q;
  logic run_q, fired_q, card_q, sel_q;
  logic [IdentAw-1:0] ident_q;
  logic [RateW-1:0] rate_q;

  // Stage 2: result holding with RAM read data merged in.
  logic s2_valid_q, s2_rx_rd_q, s2_tx_rd_q;
  rsp_t s2_q;
  logic [7:0] rx_rdata, tx_rdata;
  logic adv;
  assign adv = !s2_valid_q || rsp_ready_i;
  assign req_ready_o = adv;
  wire go = req_valid_i && adv;

  function automatic logic [RingAw-1:0] nxt(input logic [RingAw-1:0] i);
    nxt = (32'(i) + 32'd1 >= 32'(RingDepth)) ? '0 : i + RingAw'(1);
  endfunction

  function automatic logic [31:0] sat(input logic [31:0] a, input logic [15:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {17'd0, b};
    sat = s[32] ? 32'hffffffff : s[31:0];
  endfunction

  logic rx_we, rx_re, tx_we, tx_re;
  logic [RingAw-1:0] rx_h_d, rx_t_d, tx_h_d, tx_t_d;
  logic [31:0] discard_d, feed_d;
  logic [7:0] upper_d, mask_d;
  logic [IflW-1:0] ifl_d;
  logic run_d, fired_d, card_d, sel_d;
  logic [IdentAw-1:0] ident_d;
  logic [RateW-1:0] rate_d;
  rsp_t r;
  logic [15:0] amount;
  logic [7:0] wd;

  always_comb begin
    rx_h_d = rx_head_q; rx_t_d = rx_tail_q; tx_h_d = tx_head_q; tx_t_d = tx_tail_q;
    discard_d = discard_q; feed_d = feed_q; upper_d = upper_q; mask_d = mask_q;
    ifl_d = ifl_q; run_d = run_q; fired_d = fired_q; card_d = card_q; sel_d = sel_q;
    ident_d = ident_q; rate_d = rate_q;
    rx_we = 1'b0; rx_re = 1'b0; tx_we = 1'b0; tx_re = 1'b0;
    r = '0;
    r.rx_accepted = 1'b1;
    wd = req_i.write_data;
    amount = {upper_q, wd};
    case (req_i.mode)
      MODE_READ: begin
        case (req_i.address)
          REG_CARD: r.read_data = {7'd0, card_q};
          REG_RXHEAD: r.read_data = 8'(rx_head_q);
          REG_RXTAIL: r.read_data = 8'(rx_tail_q);
          REG_TXHEAD: r.read_data = 8'(tx_head_q);
          REG_TXTAIL: r.read_data = 8'(tx_tail_q);
          REG_IRQ: r.read_data = {7'd0, fired_q};
          REG_MASK: r.read_data = mask_q;
          REG_DATA: if (rx_head_q != rx_tail_q) begin
            rx_re = 1'b1;
            rx_h_d = nxt(rx_head_q);
          end
          REG_IDBYTE: begin
            r.read_data = ident_byte(4'(ident_q));
            ident_d = (32'(ident_q) + 32'd1 >= 32'(IdentLength)) ? '0 : ident_q + IdentAw'(1);
          end
          default: ;
        endcase
      end
      MODE_WRITE: begin
        case (req_i.address)
          REG_UPPER: begin upper_d = wd; run_d = 1'b1; end
          REG_DISCARD: begin discard_d = sat(discard_q, amount); upper_d = '0; run_d = 1'b1; end
          REG_FEED: begin feed_d = sat(feed_q, amount); upper_d = '0; run_d = 1'b1; end
          REG_RATE: begin
            rate_d = wd[7] ? RateW'({1'b0, wd[6:0]} * 27'd1000000)
                           : RateW'(wd * 27'd10000);
            run_d = 1'b1;
          end
          REG_SELECT: begin sel_d = (wd == 8'd1); run_d = 1'b1; end
          REG_IRQ: fired_d = 1'b0;
          REG_MASK: mask_d = wd;
          REG_DATA: if (nxt(tx_tail_q) != tx_head_q) begin
            tx_we = 1'b1;
            tx_t_d = nxt(tx_tail_q);
          end
          default: ;
        endcase
      end
      MODE_RESET: begin
        mask_d = '0; fired_d = 1'b0; run_d = 1'b0; ifl_d = '0; upper_d = '0;
        discard_d = '0; feed_d = '0;
        rx_h_d = '0; rx_t_d = '0; tx_h_d = '0; tx_t_d = '0;
        rate_d = RateAfterReset;
      end
      MODE_RXBYTE: if (run_q) begin
        if (discard_q != '0) begin
          discard_d = discard_q - 32'd1;
          if (ifl_q != '0) ifl_d = ifl_q - IflW'(1);
        end else if (nxt(rx_tail_q) == rx_head_q) begin
          r.rx_accepted = 1'b0;
        end else begin
          rx_we = 1'b1;
          rx_t_d = nxt(rx_tail_q);
          if (ifl_q != '0) ifl_d = ifl_q - IflW'(1);
        end
      end
      MODE_TXSLOT: if (run_q && 32'(ifl_q) < 32'(MaxInFlight)) begin
        if (tx_head_q != tx_tail_q) begin
          tx_re = 1'b1;
          tx_h_d = nxt(tx_head_q);
          r.tx_valid = 1'b1;
          ifl_d = ifl_q + IflW'(1);
        end else if (feed_q != '0) begin
          r.tx_byte = FillerByte;
          feed_d = feed_q - 32'd1;
          r.tx_valid = 1'b1;
          ifl_d = ifl_q + IflW'(1);
        end
      end
      MODE_CARD: if (req_i.card_present != card_q) begin
        card_d = req_i.card_present;
        if (!fired_q && mask_q[1]) fired_d = 1'b1;
      end
      default: ;
    endcase
    r.irq_asserted = fired_d;
    r.select_active = sel_d;
    r.spi_rate_hz = rate_d;
  end

  bsfb_ram #(.Width(8), .Depth(RingDepth)) u_rx_ring (
    .clk_i, .we_i(go && rx_we), .waddr_i(rx_tail_q), .wdata_i(req_i.spi_rx_byte),
    .re_i(go && rx_re), .raddr_i(rx_head_q), .rdata_o(rx_rdata)
  );
  bsfb_ram #(.Width(8), .Depth(RingDepth)) u_tx_ring (
    .clk_i, .we_i(go && tx_we), .waddr_i(tx_tail_q), .wdata_i(wd),
    .re_i(go && tx_re), .raddr_i(tx_head_q), .rdata_o(tx_rdata)
  );

  always_ff @(posedge clk_i) begin
    if (go) begin
      s2_q <= r;
      s2_rx_rd_q <= rx_re;
      s2_tx_rd_q <= tx_re;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rx_head_q <= '0; rx_tail_q <= '0; tx_head_q <= '0; tx_tail_q <= '0;
      discard_q <= '0; feed_q <= '0; upper_q <= '0; mask_q <= '0; ifl_q <= '0;
      run_q <= 1'b0; fired_q <= 1'b0; card_q <= 1'b0; sel_q <= 1'b0;
      ident_q <= '0; rate_q <= RateAfterReset; s2_valid_q <= 1'b0;
    end else begin
      if (adv) s2_valid_q <= req_valid_i;
      if (go) begin
        rx_head_q <= rx_h_d; rx_tail_q <= rx_t_d; tx_head_q <= tx_h_d; tx_tail_q <= tx_t_d;
        discard_q <= discard_d; feed_q <= feed_d; upper_q <= upper_d; mask_q <= mask_d;
        ifl_q <= ifl_d; run_q <= run_d; fired_q <= fired_d; card_q <= card_d;
        sel_q <= sel_d; ident_q <= ident_d; rate_q <= rate_d;
      end
    end
  end

  // The RAM holds its read data while the result stalls, since re is gated.
  always_comb begin
    rsp_o = s2_q;
    if (s2_rx_rd_q) rsp_o.read_data = rx_rdata;
    if (s2_tx_rd_q) rsp_o.tx_byte = tx_rdata;
  end
  assign rsp_valid_o = s2_valid_q;
endmodule
`default_nettype wire

// File: verif/tb.sv
// Testbench for bus_to_spi_fifo_bridge: a directed table, then random traffic checked by a predictor.
`timescale 1ns / 100ps
module tb;
  import bsfb_pkg::*;

  typedef struct {
    logic [2:0] mode;
    logic [3:0] addr;
    logic [7:0] wdata;
    logic [7:0] rbyte;
    logic       card;
  } request_t;

  typedef struct {
    logic [7:0]       rd;
    logic             txv;
    logic [7:0]       txb;
    logic             acc;
    logic             irq;
    logic             sel;
    logic [RateW-1:0] rate;
  } status_t;

  // directed row; chk means exp_rd was typed in by hand
  typedef struct {
    request_t   rq;
    bit         chk;
    logic [7:0] exp_rd;
  } row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [2:0]  s_axis_tuser = '0;
  logic [23:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;

  bus_to_spi_fifo_bridge dut (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tuser, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

  always #5 clk_i = ~clk_i;

  // bridge state as the predictor sees it
  logic [7:0]       rx_mem [RingDepth];
  logic [7:0]       tx_mem [RingDepth];
  logic [7:0]       rx_hd, rx_tl, tx_hd, tx_tl;
  logic [31:0]      drop_cnt, fill_cnt;
  logic [7:0]       upper_b, armed;
  int               outstanding;
  bit               running, fired, card_st, sel_st;
  logic [2:0]       id_pos;
  logic [RateW-1:0] rate_hz;
  logic [7:0]       id_rom [8] = '{8'hff, 8'h73, 8'h70, 8'h64, 8'h72, 8'h01, 8'h00, 8'h00};

  status_t status_q[$];
  bit      failed = 1'b0;
  bit      fast = 1'b0;      // no sender gaps
  bit      hold_off = 1'b0;  // receiver long stall request

  function automatic logic [31:0] sat_sum(logic [31:0] a, logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hffff_ffff : s[31:0];
  endfunction

  function automatic void clear_bus();
    armed = '0; fired = 0; running = 0; outstanding = 0; upper_b = '0;
    drop_cnt = '0; fill_cnt = '0;
    rx_hd = '0; rx_tl = '0; tx_hd = '0; tx_tl = '0;
    rate_hz = RateAfterReset;
  endfunction

  function automatic status_t bridge_step(request_t r);
    status_t    s;
    logic [15:0] amt;
    s = '{rd: '0, txv: 0, txb: '0, acc: 1, irq: 0, sel: 0, rate: '0};
    amt = {upper_b, r.wdata};
    case (r.mode)
      MODE_READ: begin
        case (r.addr)
          REG_CARD:   s.rd = {7'd0, card_st};
          REG_RXHEAD: s.rd = rx_hd;
          REG_RXTAIL: s.rd = rx_tl;
          REG_TXHEAD: s.rd = tx_hd;
          REG_TXTAIL: s.rd = tx_tl;
          REG_IRQ:    s.rd = {7'd0, fired};
          REG_MASK:   s.rd = armed;
          REG_DATA: begin
            if (rx_hd != rx_tl) begin
              s.rd = rx_mem[rx_hd];
              rx_hd++;
            end
          end
          REG_IDBYTE: begin
            s.rd = id_rom[id_pos];
            id_pos++;
          end
          default: ;
        endcase
      end
      MODE_WRITE: begin
        case (r.addr)
          REG_UPPER:   begin upper_b = r.wdata; running = 1; end
          REG_DISCARD: begin
            drop_cnt = sat_sum(drop_cnt, 32'(amt)); upper_b = '0; running = 1;
          end
          REG_FEED:    begin fill_cnt = sat_sum(fill_cnt, 32'(amt)); upper_b = '0; running = 1; end
          REG_RATE: begin
            rate_hz = (r.wdata < 128) ? RateW'(r.wdata * 10000)
                                      : RateW'((r.wdata - 128) * 1000000);
            running = 1;
          end
          REG_SELECT: begin sel_st = (r.wdata == 8'd1); running = 1; end
          REG_IRQ:    fired = 0;
          REG_MASK:   armed = r.wdata;
          REG_DATA: begin
            if (8'(tx_tl + 1) != tx_hd) begin
              tx_mem[tx_tl] = r.wdata;
              tx_tl++;
            end
          end
          default: ;
        endcase
      end
      MODE_RESET: clear_bus();
      MODE_RXBYTE: begin
        if (running) begin
          if (drop_cnt != 0) begin
            drop_cnt--;
            if (outstanding > 0) outstanding--;
          end else if (8'(rx_tl + 1) == rx_hd) begin
            s.acc = 0;
          end else begin
            rx_mem[rx_tl] = r.rbyte;
            rx_tl++;
            if (outstanding > 0) outstanding--;
          end
        end
      end
      MODE_TXSLOT: begin
        if (running && outstanding < MaxInFlight) begin
          if (tx_hd != tx_tl) begin
            s.txb = tx_mem[tx_hd];
            tx_hd++;
            s.txv = 1;
          end else if (fill_cnt != 0) begin
            s.txb = FillerByte;
            fill_cnt--;
            s.txv = 1;
          end
          if (s.txv) outstanding++;
        end
      end
      MODE_CARD: begin
        if (r.card != card_st) begin
          card_st = r.card;
          if (!fired && armed[1]) fired = 1;
        end
      end
      default: ;  // unused modes leave everything alone
    endcase
    s.irq = fired;
    s.sel = sel_st;
    s.rate = rate_hz;
    return s;
  endfunction

  // Send one request, wait for the handshake, then log what it must produce.
  task automatic send(request_t r, bit chk = 0, logic [7:0] exp_rd = '0);
    int      gap;
    status_t s;
    gap = 0;
    if (!fast) begin
      if ($urandom_range(0, 19) == 0) gap = $urandom_range(8, 40);
      else if ($urandom_range(0, 2) == 0) gap = $urandom_range(1, 3);
    end
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tuser  <= r.mode;
    s_axis_tdata  <= {3'd0, r.card, r.rbyte, r.wdata, r.addr};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    s = bridge_step(r);
    if (chk) s.rd = exp_rd;
    status_q.push_back(s);
  endtask

  function automatic request_t mk(logic [2:0] m, logic [3:0] a = '0, logic [7:0] d = '0);
    request_t r;
    r.mode = m; r.addr = a; r.wdata = d;
    r.rbyte = 8'($urandom); r.card = 1'($urandom);
    return r;
  endfunction

  // Random request mix; mostly traffic that keeps the rings moving.
  function automatic request_t rand_req();
    request_t r;
    int       p;
    r = mk(MODE_READ, 4'($urandom), 8'($urandom));
    p = $urandom_range(0, 99);
    if (p < 22) begin
      r.mode = MODE_READ;
      if ($urandom_range(0, 1)) r.addr = REG_DATA;
    end else if (p < 52) begin
      r.mode = MODE_WRITE;
      case ($urandom_range(0, 9))
        0, 1, 2: r.addr = REG_DATA;
        3: begin r.addr = REG_UPPER; r.wdata = 8'($urandom_range(0, 2)); end
        4: begin r.addr = REG_DISCARD; r.wdata = 8'($urandom_range(0, 6)); end
        5: begin r.addr = REG_FEED; r.wdata = 8'($urandom_range(0, 12)); end
        6: r.addr = REG_RATE;
        7: begin r.addr = REG_SELECT; r.wdata = 8'($urandom_range(0, 2)); end
        8: r.addr = $urandom_range(0, 1) ? REG_IRQ : REG_MASK;
        default: ;
      endcase
    end else if (p < 54) begin
      r.mode = MODE_RESET;
    end else if (p < 73) begin
      r.mode = MODE_RXBYTE;
    end else if (p < 93) begin
      r.mode = MODE_TXSLOT;
    end else if (p < 98) begin
      r.mode = MODE_CARD;
    end else begin
      r.mode = 3'($urandom_range(6, 7));
    end
    return r;
  endfunction

  // Receiver: random stalls, plus one long hold-off on request.
  initial begin
    int n;
    @(posedge rst_ni);
    forever begin
      if (hold_off) begin
        m_axis_tready <= 1'b0;
        repeat (400) @(posedge clk_i);
        hold_off = 0;
      end else begin
        n = $urandom_range(0, 99);
        if (n == 99) begin
          m_axis_tready <= 1'b0;
          repeat ($urandom_range(10, 60)) @(posedge clk_i);
        end else if (fast || n < 70) begin
          m_axis_tready <= 1'b1;
        end else begin
          m_axis_tready <= 1'b0;
        end
        @(posedge clk_i);
      end
    end
  end

  // Result checker
  always @(posedge clk_i) begin
    status_t e;
    if (m_axis_tvalid && m_axis_tready) begin
      if (status_q.size() == 0) begin
        $error("result with nothing expected: %h", m_axis_tdata);
        failed = 1;
      end else begin
        e = status_q.pop_front();
        if (m_axis_tdata[7:0] !== e.rd) begin
          $error("read_data exp %h got %h", e.rd, m_axis_tdata[7:0]); failed = 1;
        end
        if (m_axis_tdata[8] !== e.txv) begin
          $error("tx_valid exp %b got %b", e.txv, m_axis_tdata[8]); failed = 1;
        end
        if (m_axis_tdata[16:9] !== e.txb) begin
          $error("tx_byte exp %h got %h", e.txb, m_axis_tdata[16:9]); failed = 1;
        end
        if (m_axis_tdata[17] !== e.acc) begin
          $error("rx_accepted exp %b got %b", e.acc, m_axis_tdata[17]); failed = 1;
        end
        if (m_axis_tdata[18] !== e.irq) begin
          $error("irq_asserted exp %b got %b", e.irq, m_axis_tdata[18]); failed = 1;
        end
        if (m_axis_tdata[19] !== e.sel) begin
          $error("select_active exp %b got %b", e.sel, m_axis_tdata[19]); failed = 1;
        end
        if (m_axis_tdata[46:20] !== e.rate) begin
          $error("spi_rate_hz exp %0d got %0d", e.rate, m_axis_tdata[46:20]); failed = 1;
        end
      end
    end
  end

  initial begin
    #15_000_000;
    $display("FAIL bus_to_spi_fifo_bridge");
    $finish;
  end

  row_t rows[$];

  initial begin
    int w;
    clear_bus();
    card_st = 0; sel_st = 0; id_pos = '0;
    rows = '{
      '{mk(MODE_READ, REG_CARD), 1, 8'h00},
      '{mk(MODE_READ, REG_IDBYTE), 1, 8'hff},
      '{mk(MODE_READ, REG_IDBYTE), 1, 8'h73},
      '{mk(MODE_READ, REG_DATA), 1, 8'h00},          // empty rx ring
      '{mk(MODE_RXBYTE), 0, 0},                       // idle: drained
      '{mk(MODE_TXSLOT), 0, 0},                       // idle: nothing sent
      '{mk(MODE_WRITE, REG_RATE, 8'hff), 0, 0},       // top rate
      '{mk(MODE_WRITE, REG_RATE, 8'h00), 0, 0},
      '{mk(MODE_WRITE, REG_RATE, 8'h7f), 0, 0},
      '{mk(MODE_WRITE, REG_SELECT, 8'h01), 0, 0},
      '{mk(MODE_WRITE, REG_MASK, 8'h02), 0, 0},
      '{mk(MODE_CARD, 4'd0, 8'd0), 0, 0},
      '{mk(MODE_READ, REG_IRQ), 0, 0},
      '{mk(MODE_WRITE, REG_IRQ), 0, 0},
      '{mk(MODE_WRITE, REG_DATA, 8'ha5), 0, 0},
      '{mk(MODE_WRITE, REG_FEED, 8'h02), 0, 0},
      '{mk(MODE_TXSLOT), 0, 0},                       // ring byte
      '{mk(MODE_TXSLOT), 0, 0},                       // filler
      '{mk(MODE_RXBYTE), 0, 0},
      '{mk(MODE_READ, REG_DATA), 0, 0},
      '{mk(MODE_WRITE, REG_UPPER, 8'hff), 0, 0},
      '{mk(MODE_WRITE, REG_DISCARD, 8'hff), 0, 0},
      '{mk(3'd6), 0, 0},
      '{mk(3'd7), 0, 0},
      '{mk(MODE_RESET), 0, 0},
      '{mk(MODE_READ, REG_TXTAIL), 1, 8'h00}
    };
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[i]) send(rows[i].rq, rows[i].chk, rows[i].exp_rd);

    // long receiver stall while requests keep coming, so the input backs up
    hold_off = 1;
    for (int i = 0; i < 60; i++) send(rand_req());

    // ring-full cases: fill tx ring past capacity, then rx ring past capacity
    send(mk(MODE_WRITE, REG_SELECT, 8'h00));
    for (int i = 0; i < 258; i++) send(mk(MODE_WRITE, REG_DATA, 8'($urandom)));
    for (int i = 0; i < 12; i++) send(mk(MODE_TXSLOT));  // runs into the in-flight cap
    for (int i = 0; i < 258; i++) send(mk(MODE_RXBYTE));
    send(mk(MODE_RESET));

    // rate code right at the split, then a short burst with no idling
    fast = 1;
    send(mk(MODE_WRITE, REG_RATE, 8'h80));
    for (int i = 0; i < 10; i++) send($urandom_range(0, 1) ? mk(MODE_TXSLOT) : mk(MODE_RXBYTE));
    fast = 0;
    send(mk(MODE_RESET));

    for (int i = 0; i < 230; i++) begin
      if (i % 50 == 0) fast = $urandom_range(0, 1);  // stretches with no idling
      send(rand_req());
    end
    s_axis_tvalid <= 1'b0;

    w = 0;
    while (status_q.size() != 0 && w < 100000) begin
      @(posedge clk_i);
      w++;
    end
    repeat (10) @(posedge clk_i);
    if (!failed && status_q.size() == 0) begin
      $display("PASS bus_to_spi_fifo_bridge");
    end else begin
      $display("FAIL bus_to_spi_fifo_bridge");
    end
    $finish;
  end
endmodule

// File: bus_to_spi_fifo_bridge.f
rtl/bsfb_pkg.sv
rtl/bsfb_ram.sv
rtl/bsfb_queue.sv
rtl/bsfb_engine.sv
rtl/bus_to_spi_fifo_bridge.sv
verif/tb.sv
